FILE: hw/rtl/pulse_beat_rate_detector_defines.svh
// ----------------------------------------------------------------------------
// Pulse beat rate detector: assertion macros
// Shared property forms for the checker. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH

// condition implies property in the same cycle
`define PBRD_ASSERT_SAME(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// condition implies property in the next cycle
`define PBRD_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: hw/rtl/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// Pulse beat rate detector package
// Field widths, register indexes, reset values and the sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrd_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int LEVEL_W    = 10;
	localparam int MS_W       = 16;
	localparam int BPM_W      = 8;
	localparam int STEP_W     = 4;
	localparam int REFR_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LVL = 2'd3;

	localparam logic [STEP_W-1:0]  RST_STEP       = 4'd2;
	localparam logic [REFR_W-1:0]  RST_REFRACTORY = 12'd250;
	localparam logic [MS_W-1:0]    RST_TIMEOUT    = 16'd2500;
	localparam logic [LEVEL_W-1:0] RST_LEVEL      = 10'd512;
	localparam logic [MS_W-1:0]    RST_INTERVAL   = 16'd600;
	// three fifths of the reset interval
	localparam logic [MS_W-1:0]    RST_GUARD      = 16'd360;

	// one fifth scaled by 2^18, exact floor for any 16-bit interval
	localparam logic [MS_W-1:0]    GUARD_RECIP = 16'd52429;
	localparam int                 GUARD_SH    = 18;
	localparam logic [MS_W-1:0]    BPM_NUM     = 16'd60000;
	localparam logic [BPM_W-1:0]   BPM_MAX     = 8'd255;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_EVAL  = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_POST  = 9'b000001000,
		S_SEED  = 9'b000010000,
		S_RDOLD = 9'b000100000,
		S_UPD   = 9'b001000000,
		S_MUL   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		OP_GUARD = 2'd0,
		OP_MEAN  = 2'd1,
		OP_BPM   = 2'd2
	} div_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pulse_beat_rate_detector.sv
// ----------------------------------------------------------------------------
// Pulse beat rate detector
// Adaptive threshold beat finder on a pulse sensor stream, with interval
// history and beats per minute from one restoring divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//  sample    in         sample_valid/sample_ready raw_sample
//  result    out        result_valid/result_ready beat_found, bpm, interval_ms,
//                                                 pulse_high, threshold_level
//
//  A sample without a beat runs S_EVAL, S_OUT; a first beat runs S_EVAL,
//  S_MUL, S_POST, S_OUT; a counted beat S_EVAL, S_MUL, S_POST, S_RDOLD, S_UPD,
//  S_MUL, S_POST, S_DIV, S_POST, S_OUT, plus S_SEED per entry when it seeds
//  the history. The radix-2 rate divider gives one quotient bit per cycle;
//  guard and mean interval are reciprocal products. One sample is in work
//  at a time; the result register lets the next sample in while a result
//  waits. Reset is asynchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_beat_rate_detector #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [pbrd_pkg::SAMPLE_W-1:0]   raw_sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic                            beat_found,
	output logic [pbrd_pkg::BPM_W-1:0]      bpm,
	output logic [pbrd_pkg::MS_W-1:0]       interval_ms,
	output logic                            pulse_high,
	output logic [pbrd_pkg::LEVEL_W-1:0]    threshold_level
);
	import pbrd_pkg::*;

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int DIV_W = MS_W + $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);
	// reciprocal of the depth, exact floor for any history sum
	localparam int MEAN_SH = DIV_W + PTR_W;
	localparam int MUL_W   = DIV_W + MEAN_SH;
	localparam logic [MEAN_SH-1:0] MEAN_RECIP = MEAN_SH'(((64'd1 << MEAN_SH)
		+ 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

	state_t state_q;

	// configuration
	logic [STEP_W-1:0]  step_q;
	logic [REFR_W-1:0]  refr_q;
	logic [MS_W-1:0]    tout_q;
	logic [LEVEL_W-1:0] dflt_q;

	// detector state
	logic [MS_W-1:0]    tc_q;
	logic [MS_W-1:0]    lbt_q;
	logic [MS_W-1:0]    interval_q;
	logic [MS_W-1:0]    guard_q;
	logic [LEVEL_W-1:0] peak_q;
	logic [LEVEL_W-1:0] trough_q;
	logic [LEVEL_W-1:0] thresh_q;
	logic               pulse_q;
	logic               first_q;
	logic               second_q;
	logic [BPM_W-1:0]   bpm_q;

	// per sample work
	logic [LEVEL_W-1:0] sig_q;
	logic               found_q;
	logic               seed_q;
	logic               calc_q;

	// interval history, circular
	logic [MS_W-1:0]    hist_q [HISTORY_DEPTH];
	logic [MS_W-1:0]    old_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [DIV_W-1:0]   sum_q;
	logic               hist_we;

	// rate divider
	logic [DIV_W-1:0]   div_quo_q;
	logic [MS_W-1:0]    div_rem_q;
	logic [MS_W-1:0]    div_den_q;
	logic [CNT_W-1:0]   div_cnt_q;
	div_op_t            div_op_q;
	logic [MS_W:0]      div_trial;
	logic [MS_W:0]      div_diff;
	logic               div_ge;
	logic [MS_W-1:0]    div_rem_n;
	logic [DIV_W-1:0]   div_quo_n;

	// reciprocal product for guard and mean
	logic [DIV_W-1:0]   mul_a;
	logic [MEAN_SH-1:0] mul_b;
	logic [MUL_W-1:0]   mul_q;
	logic [MS_W-1:0]    guard_quo;
	logic [MS_W-1:0]    mean_quo;

	// result register
	logic               res_valid_q;
	logic               res_found_q;
	logic [BPM_W-1:0]   res_bpm_q;
	logic [MS_W-1:0]    res_interval_q;
	logic               res_pulse_q;
	logic [LEVEL_W-1:0] res_thresh_q;

	// evaluation of one sample
	logic [MS_W-1:0]    elapsed;
	logic               above;
	logic               below;
	logic               past_guard;
	logic               beat;
	logic               fall;
	logic               tout;
	logic [LEVEL_W-1:0] peak_n;
	logic [LEVEL_W-1:0] trough_n;
	logic [LEVEL_W:0]   amp;
	logic [LEVEL_W:0]   amp_adj;
	logic [LEVEL_W-1:0] fall_lvl;

	always_comb begin
		elapsed    = tc_q - lbt_q;
		above      = sig_q > thresh_q;
		below      = sig_q < thresh_q;
		past_guard = elapsed > guard_q;
		trough_n   = (below && past_guard && (sig_q < trough_q)) ? sig_q : trough_q;
		peak_n     = (above && (sig_q > peak_q)) ? sig_q : peak_q;
		beat       = (elapsed > {{(MS_W-REFR_W){1'b0}}, refr_q}) && above && !pulse_q
			&& past_guard;
		fall       = below && pulse_q;
		tout       = elapsed > tout_q;
		// half the signed amplitude, truncated toward zero
		amp        = {1'b0, peak_n} - {1'b0, trough_n};
		amp_adj    = amp + {{LEVEL_W{1'b0}}, amp[LEVEL_W]};
		fall_lvl   = trough_n + amp_adj[LEVEL_W:1];
	end

	always_comb begin
		div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
		div_diff  = div_trial - {1'b0, div_den_q};
		div_ge    = div_trial >= {1'b0, div_den_q};
		div_rem_n = div_ge ? div_diff[MS_W-1:0] : div_trial[MS_W-1:0];
		div_quo_n = {div_quo_q[DIV_W-2:0], div_ge};
	end

	always_comb begin
		if (div_op_q == OP_MEAN) begin
			mul_a = sum_q;
			mul_b = MEAN_RECIP;
		end else begin
			mul_a = DIV_W'(interval_q);
			mul_b = MEAN_SH'(GUARD_RECIP);
		end
		guard_quo = mul_q[GUARD_SH +: MS_W];
		mean_quo  = mul_q[MEAN_SH +: MS_W];
	end

	assign hist_we = state_q inside {S_SEED, S_UPD};

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_q[ptr_q] <= interval_q;
		end
		if (state_q == S_RDOLD) begin
			old_q <= hist_q[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= RST_STEP;
			refr_q         <= RST_REFRACTORY;
			tout_q         <= RST_TIMEOUT;
			dflt_q         <= RST_LEVEL;
			tc_q           <= '0;
			lbt_q          <= '0;
			interval_q     <= RST_INTERVAL;
			guard_q        <= RST_GUARD;
			peak_q         <= RST_LEVEL;
			trough_q       <= RST_LEVEL;
			thresh_q       <= RST_LEVEL;
			pulse_q        <= 1'b0;
			first_q        <= 1'b1;
			second_q       <= 1'b0;
			bpm_q          <= '0;
			sig_q          <= '0;
			found_q        <= 1'b0;
			seed_q         <= 1'b0;
			calc_q         <= 1'b0;
			ptr_q          <= '0;
			sum_q          <= '0;
			div_quo_q      <= '0;
			div_rem_q      <= '0;
			div_den_q      <= '0;
			div_cnt_q      <= '0;
			div_op_q       <= OP_GUARD;
			mul_q          <= '0;
			res_valid_q    <= 1'b0;
			res_found_q    <= 1'b0;
			res_bpm_q      <= '0;
			res_interval_q <= '0;
			res_pulse_q    <= 1'b0;
			res_thresh_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SAMPLE_STEP: step_q <= cfg_data[STEP_W-1:0];
					CFG_REFRACTORY:  refr_q <= cfg_data[REFR_W-1:0];
					CFG_TIMEOUT:     tout_q <= cfg_data[MS_W-1:0];
					CFG_DEFAULT_LVL: dflt_q <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end

			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						sig_q   <= raw_sample[SAMPLE_W-1:SAMPLE_W-LEVEL_W];
						tc_q    <= tc_q + {{(MS_W-STEP_W){1'b0}}, step_q};
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					found_q  <= 1'b0;
					peak_q   <= peak_n;
					trough_q <= trough_n;
					if (beat) begin
						pulse_q    <= 1'b1;
						interval_q <= elapsed;
						lbt_q      <= tc_q;
						seed_q     <= second_q;
						calc_q     <= !first_q;
						found_q    <= !first_q;
						second_q   <= 1'b0;
						if (first_q) begin
							first_q  <= 1'b0;
							second_q <= 1'b1;
						end
						// guard for the new interval
						div_op_q <= OP_GUARD;
						state_q  <= S_MUL;
					end else begin
						state_q <= S_OUT;
						if (fall) begin
							pulse_q  <= 1'b0;
							thresh_q <= fall_lvl;
							peak_q   <= fall_lvl;
							trough_q <= fall_lvl;
						end
					end
					// a first beat skips the timeout
					if (tout && !(beat && first_q)) begin
						thresh_q <= dflt_q;
						peak_q   <= dflt_q;
						trough_q <= dflt_q;
						lbt_q    <= tc_q;
						first_q  <= 1'b1;
						second_q <= 1'b0;
					end
				end
				S_MUL: begin
					mul_q   <= MUL_W'(mul_a) * MUL_W'(mul_b);
					state_q <= S_POST;
				end
				S_DIV: begin
					div_quo_q <= div_quo_n;
					div_rem_q <= div_rem_n;
					div_cnt_q <= div_cnt_q - CNT_W'(1);
					if (div_cnt_q == '0) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					case (div_op_q)
						OP_GUARD: begin
							guard_q <= guard_quo + {guard_quo[MS_W-2:0], 1'b0};
							if (seed_q) begin
								ptr_q   <= '0;
								sum_q   <= '0;
								state_q <= S_SEED;
							end else if (calc_q) begin
								state_q <= S_RDOLD;
							end else begin
								state_q <= S_OUT;
							end
						end
						OP_MEAN: begin
							if (mean_quo == '0) begin
								bpm_q   <= BPM_MAX;
								state_q <= S_OUT;
							end else begin
								div_quo_q <= DIV_W'(BPM_NUM);
								div_rem_q <= '0;
								div_den_q <= mean_quo;
								div_cnt_q <= CNT_W'(DIV_W - 1);
								div_op_q  <= OP_BPM;
								state_q   <= S_DIV;
							end
						end
						OP_BPM: begin
							// saturate the rate
							bpm_q   <= (div_quo_q > DIV_W'(BPM_MAX)) ? BPM_MAX
								: div_quo_q[BPM_W-1:0];
							state_q <= S_OUT;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_SEED: begin
					sum_q <= sum_q + DIV_W'(interval_q);
					if (ptr_q == LAST_PTR) begin
						ptr_q   <= '0;
						state_q <= calc_q ? S_RDOLD : S_OUT;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				S_RDOLD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					// drop the oldest interval, add the newest
					sum_q    <= sum_q - DIV_W'(old_q) + DIV_W'(interval_q);
					ptr_q    <= (ptr_q == LAST_PTR) ? '0 : ptr_q + PTR_W'(1);
					div_op_q <= OP_MEAN;
					state_q  <= S_MUL;
				end
				S_OUT: begin
					if (!res_valid_q || result_ready) begin
						res_valid_q    <= 1'b1;
						res_found_q    <= found_q;
						res_bpm_q      <= bpm_q;
						res_interval_q <= interval_q;
						res_pulse_q    <= pulse_q;
						res_thresh_q   <= thresh_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready       = 1'b1;
	assign sample_ready    = (state_q == S_IDLE);
	assign result_valid    = res_valid_q;
	assign beat_found      = res_found_q;
	assign bpm             = res_bpm_q;
	assign interval_ms     = res_interval_q;
	assign pulse_high      = res_pulse_q;
	assign threshold_level = res_thresh_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pbrd_checker.sv
// ----------------------------------------------------------------------------
// Pulse beat rate detector checker
// Port level properties of the detector, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_beat_rate_detector_defines.svh"

module pbrd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            sample_valid,
	input logic                            sample_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic                            beat_found,
	input logic [pbrd_pkg::BPM_W-1:0]      bpm,
	input logic [pbrd_pkg::MS_W-1:0]       interval_ms,
	input logic                            pulse_high,
	input logic [pbrd_pkg::LEVEL_W-1:0]    threshold_level
);
	import pbrd_pkg::*;

	// hold a stalled result word
	`PBRD_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid, "result word dropped while stalled")
	`PBRD_ASSERT_NEXT(a_res_stable, result_valid && !result_ready, ($stable(bpm) && $stable(interval_ms) && $stable(threshold_level) && $stable(beat_found) && $stable(pulse_high)), "stalled result word changed")
	// one sample word in work at a time
	`PBRD_ASSERT_NEXT(a_one_item, sample_valid && sample_ready, !sample_ready, "sample taken while busy")
	// a counted beat leaves the pulse high and a nonzero interval
	`PBRD_ASSERT_SAME(a_beat_pulse, result_valid && beat_found, (pulse_high && (interval_ms != '0)), "counted beat without pulse or interval")

endmodule

bind pulse_beat_rate_detector pbrd_checker u_pbrd_checker (.*);

`default_nettype wire
